>>> rtl/core/hlsfr_pkg.sv
// Shared types and constants for the header/length/checksum frame receiver.
`default_nettype none
package hlsfr_pkg;

  localparam int LENGTH_LIMIT = 50;
  localparam int STORE_DEPTH  = LENGTH_LIMIT - 1;
  localparam int IDX_W        = $clog2(LENGTH_LIMIT);

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hAF;
  localparam logic [7:0] FUNC_END   = 8'hF1;
  localparam logic [7:0] ACK_LOW    = 8'h10;
  localparam logic [7:0] ACK_HIGH   = 8'h15;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR1,
    PH_HDR2,
    PH_FUNC,
    PH_DATA,
    PH_SUM
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD,
    BK_LD,
    BK_BAD
  } back_state_e;

  // One finished frame handed from the parser to the emitter.
  typedef struct packed {
    logic             ok;
    logic [7:0]       func;
    logic [IDX_W-1:0] len;
    logic [7:0]       sum;
  } job_t;

  // Job queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/hlsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hlsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 49
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/hlsfr_job_q.sv
// Two-entry job queue between the frame parser and the result emitter.
`default_nettype none
module hlsfr_job_q import hlsfr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire job_t    job_i,
  input  wire logic    pop_i,
  output job_t         job_o,
  output q_stat_t      stat_o
);

  job_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = entry_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hlsfr_front.sv
// Frame parser: header hunt, length and running checksum, payload writes.
`default_nettype none
module hlsfr_front import hlsfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  full,
  input  wire logic             back_busy_i,
  input  wire q_stat_t          q_stat_i,
  output logic                  ram_we_o,
  output logic [IDX_W-1:0]      ram_waddr_o,
  output logic [7:0]            ram_wdata_o,
  output logic                  job_push_o,
  output job_t                  job_o
);

  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] left_q, left_d;
  logic [IDX_W-1:0] stored_q, stored_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       func_q, func_d;
  logic             accept;
  logic [7:0]       sum_add;

  // Hold payload bytes off while the emitter still reads the store, and the checksum byte while the job queue is full.
  assign full = ((phase_q == PH_DATA) && (left_q != '0) && back_busy_i)
             || ((phase_q == PH_SUM) && q_stat_i.full);
  assign accept  = push && !full;
  assign sum_add = sum_q + rx_byte_i;

  assign ram_waddr_o = stored_q;
  assign ram_wdata_o = rx_byte_i;

  assign job_o.ok   = (rx_byte_i == sum_q);
  assign job_o.func = func_q;
  assign job_o.len  = stored_q;
  assign job_o.sum  = sum_q;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    stored_d    = stored_q;
    sum_d       = sum_q;
    func_d      = func_q;
    ram_we_o    = 1'b0;
    job_push_o  = 1'b0;
    if (accept) begin
      priority if (phase_q == PH_IDLE && rx_byte_i == HDR_FIRST) begin
        phase_d = PH_HDR1;
        sum_d   = rx_byte_i;
      end else if (phase_q == PH_HDR1 && rx_byte_i == HDR_SECOND) begin
        phase_d = PH_HDR2;
        sum_d   = sum_add;
      end else if (phase_q == PH_HDR2 && rx_byte_i != 8'h00 && rx_byte_i < FUNC_END) begin
        phase_d = PH_FUNC;
        func_d  = rx_byte_i;
        sum_d   = sum_add;
      end else if (phase_q == PH_FUNC && rx_byte_i < 8'(LENGTH_LIMIT)) begin
        phase_d  = PH_DATA;
        left_d   = rx_byte_i[IDX_W-1:0];
        stored_d = '0;
        sum_d    = sum_add;
      end else if (phase_q == PH_DATA && left_q != '0) begin
        ram_we_o = 1'b1;
        stored_d = stored_q + 1'b1;
        left_d   = left_q - 1'b1;
        sum_d    = sum_add;
        if (left_q == IDX_W'(1)) begin
          phase_d = PH_SUM;
        end
      end else if (phase_q == PH_SUM) begin
        phase_d    = PH_IDLE;
        job_push_o = 1'b1;
      end else begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      left_q   <= '0;
      stored_q <= '0;
      sum_q    <= '0;
      func_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      stored_q <= stored_d;
      sum_q    <= sum_d;
      func_q   <= func_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hlsfr_back.sv
// Result emitter: walks the payload store for a good frame, or reports a bad one.
`default_nettype none
module hlsfr_back import hlsfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire q_stat_t          q_stat_i,
  input  wire job_t             job_i,
  output logic                  job_pop_o,
  output logic                  busy_o,
  output logic [IDX_W-1:0]      ram_raddr_o,
  input  wire logic [7:0]       ram_rdata_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  frame_ok_o,
  output logic [7:0]            function_code_o,
  output logic [IDX_W-1:0]      payload_length_o,
  output logic [IDX_W-1:0]      payload_index_o,
  output logic [7:0]            payload_byte_o,
  output logic [7:0]            frame_sum_o,
  output logic                  ack_wanted_o,
  output logic                  last_o
);

  back_state_e      state_q, state_d;
  job_t             job_q, job_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ovld_q, ovld_d;
  logic             load, load_ok, slot_free, is_last;

  assign slot_free   = !ovld_q || pop;
  assign busy_o      = (state_q != BK_IDLE);
  assign ram_raddr_o = idx_q;
  assign empty       = !ovld_q;
  assign is_last     = (idx_q + 1'b1 == job_q.len);

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    idx_d     = idx_q;
    job_pop_o = 1'b0;
    load      = 1'b0;
    load_ok   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          idx_d     = '0;
          state_d   = job_i.ok ? BK_RD : BK_BAD;
        end
      end
      // address settles on idx_q; data is ready the next cycle
      BK_RD: state_d = BK_LD;
      BK_LD: begin
        if (slot_free) begin
          load    = 1'b1;
          load_ok = 1'b1;
          if (is_last) begin
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = BK_RD;
          end
        end
      end
      BK_BAD: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    ovld_d = load ? 1'b1 : (pop ? 1'b0 : ovld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (load) begin
      frame_ok_o       <= load_ok;
      function_code_o  <= job_q.func;
      payload_length_o <= job_q.len;
      payload_index_o  <= load_ok ? idx_q : '0;
      payload_byte_o   <= load_ok ? ram_rdata_i : 8'h00;
      frame_sum_o      <= job_q.sum;
      ack_wanted_o     <= (job_q.func >= ACK_LOW) && (job_q.func <= ACK_HIGH);
      last_o           <= load_ok ? is_last : 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/header_length_sum_frame_receiver.sv
// Top level of the header/length/checksum frame receiver.
// The checksum beat pushes a job into the queue; the emitter pops it, reads the store and
//   loads the output register, or for a bad frame loads its single result straight away.
// Throughput: one input beat per cycle while full is low; a good frame emits its results
//   at the pace of the registered read of the payload store (address step, then load step).
// Payload beats of the next frame stall (full high) until the emitter drains the store.
// Reset (rst_ni low, async): parser idle, job queue and output register empty.
`default_nettype none
module header_length_sum_frame_receiver import hlsfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input side: queue-style push/full
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       rx_byte_i,
  // result side: queue-style empty/pop
  output logic                  empty,
  input  wire logic             pop,
  output logic                  frame_ok_o,
  output logic [7:0]            function_code_o,
  output logic [IDX_W-1:0]      payload_length_o,
  output logic [IDX_W-1:0]      payload_index_o,
  output logic [7:0]            payload_byte_o,
  output logic [7:0]            frame_sum_o,
  output logic                  ack_wanted_o,
  output logic                  last_o
);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             job_push, job_pop;
  job_t             job_in, job_out;
  q_stat_t          q_stat;
  logic             emit_busy;
  logic             back_busy;

  // Store stays owned by the emitter while a job is queued or being walked.
  assign back_busy = emit_busy || !q_stat.empty;

  hlsfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .rx_byte_i   (rx_byte_i),
    .full        (full),
    .back_busy_i (back_busy),
    .q_stat_i    (q_stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  hlsfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hlsfr_job_q u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  hlsfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .job_i            (job_out),
    .job_pop_o        (job_pop),
    .busy_o           (emit_busy),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .empty            (empty),
    .pop              (pop),
    .frame_ok_o       (frame_ok_o),
    .function_code_o  (function_code_o),
    .payload_length_o (payload_length_o),
    .payload_index_o  (payload_index_o),
    .payload_byte_o   (payload_byte_o),
    .frame_sum_o      (frame_sum_o),
    .ack_wanted_o     (ack_wanted_o),
    .last_o           (last_o)
  );

  // payload writes never overlap an emitter walk of the store
  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !back_busy)
    else $error("payload write while store is being read");

  // a finished frame always finds room in the job queue
  a_job_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !q_stat.full)
    else $error("job queue overflow");

  // only a good frame yields a run longer than one beat
  a_not_last_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> frame_ok_o)
    else $error("non-final beat from a bad frame");

  // bad-frame report carries zero index and byte
  a_bad_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !frame_ok_o) |-> (payload_index_o == '0 && payload_byte_o == 8'h00))
    else $error("bad-frame beat with nonzero payload fields");

endmodule
`default_nettype wire

>>> dv/tb_header_length_sum_frame_receiver.sv
// Testbench for the header/length/checksum frame receiver: directed and random byte streams.
`timescale 1ns / 1ps
module tb_header_length_sum_frame_receiver;
  import hlsfr_pkg::*;

  // Run limits. The run sends roughly 480 bytes with sender gaps; CYCLE_LIMIT is set to hold
  // the run even if every byte raised a full 49-beat run, each beat behind a receiver stall.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 8;   // covers the path from the checksum to the first result
  localparam int TAIL_CYCLES  = 24;

  // One expected beat on the result side.
  typedef struct packed {
    logic             ok;
    logic [7:0]       func;
    logic [IDX_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [7:0]       sum;
    logic             ack;
    logic             last;
  } frame_result_t;

  // Receiver pop behavior, switched at random intervals.
  typedef enum logic [1:0] {
    DRAIN_FULL,
    DRAIN_HALF,
    DRAIN_TRICKLE
  } drain_mode_e;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push   = 1'b0;
  logic             pop    = 1'b0;
  logic [7:0]       rx_byte = 8'h00;
  logic             full;
  logic             empty;
  logic             frame_ok;
  logic [7:0]       function_code;
  logic [IDX_W-1:0] payload_length;
  logic [IDX_W-1:0] payload_index;
  logic [7:0]       payload_byte;
  logic [7:0]       frame_sum;
  logic             ack_wanted;
  logic             last;

  header_length_sum_frame_receiver dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte),
    .empty            (empty),
    .pop              (pop),
    .frame_ok_o       (frame_ok),
    .function_code_o  (function_code),
    .payload_length_o (payload_length),
    .payload_index_o  (payload_index),
    .payload_byte_o   (payload_byte),
    .frame_sum_o      (frame_sum),
    .ack_wanted_o     (ack_wanted),
    .last_o           (last)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser shadow: same phases as the block, advanced once per accepted beat.
  // ---------------------------------------------------------------------------
  phase_e           frame_phase  = PH_IDLE;
  logic [IDX_W-1:0] bytes_left   = '0;
  logic [IDX_W-1:0] bytes_stored = '0;
  logic [7:0]       running_sum  = '0;
  logic [7:0]       held_func    = '0;
  logic [7:0]       payload_copy [STORE_DEPTH];

  frame_result_t    frame_results_q [$];   // results still owed by the block
  int               fail_count  = 0;
  int               bytes_sent  = 0;
  int               cycle_count = 0;

  // Sender burst state.
  bit               sender_idles = 1'b1;
  int               burst_left   = 0;

  // Receiver stall state.
  drain_mode_e      drain_mode  = DRAIN_FULL;
  int               drain_ticks = 0;

  function automatic void parse_byte_into_frames(input logic [7:0] b);
    frame_result_t r;
    if (frame_phase == PH_IDLE && b == HDR_FIRST) begin
      frame_phase = PH_HDR1;
      running_sum = b;
    end else if (frame_phase == PH_HDR1 && b == HDR_SECOND) begin
      frame_phase = PH_HDR2;
      running_sum = running_sum + b;
    end else if (frame_phase == PH_HDR2 && b != 8'h00 && b < FUNC_END) begin
      frame_phase = PH_FUNC;
      held_func   = b;
      running_sum = running_sum + b;
    end else if (frame_phase == PH_FUNC && b < LENGTH_LIMIT) begin
      // a zero length lands here too; the next byte then drops it back to idle
      frame_phase  = PH_DATA;
      bytes_left   = b[IDX_W-1:0];
      bytes_stored = '0;
      running_sum  = running_sum + b;
    end else if (frame_phase == PH_DATA && bytes_left != 0) begin
      payload_copy[bytes_stored] = b;
      bytes_stored = bytes_stored + 1'b1;
      bytes_left   = bytes_left - 1'b1;
      running_sum  = running_sum + b;
      if (bytes_left == 0) frame_phase = PH_SUM;
    end else if (frame_phase == PH_SUM) begin
      frame_phase = PH_IDLE;
      r.func = held_func;
      r.len  = bytes_stored;
      r.sum  = running_sum;
      r.ack  = (held_func >= ACK_LOW && held_func <= ACK_HIGH);
      if (b == running_sum) begin
        // good frame: one beat per stored payload byte
        for (int i = 0; i < bytes_stored; i++) begin
          r.ok   = 1'b1;
          r.idx  = IDX_W'(i);
          r.data = payload_copy[i];
          r.last = (i == bytes_stored - 1);
          frame_results_q.push_back(r);
        end
      end else begin
        // bad checksum: a single beat, no payload
        r.ok   = 1'b0;
        r.idx  = '0;
        r.data = '0;
        r.last = 1'b1;
        frame_results_q.push_back(r);
      end
    end else begin
      // anything out of place drops back to idle and is not looked at again
      frame_phase = PH_IDLE;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop pattern at the falling edge, check at the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (drain_ticks == 0) begin
      drain_mode  = drain_mode_e'($urandom_range(0, 2));
      drain_ticks = $urandom_range(16, 96);
    end
    drain_ticks--;
    case (drain_mode)
      DRAIN_FULL:    pop <= 1'b1;
      DRAIN_HALF:    pop <= 1'($urandom_range(0, 1));
      DRAIN_TRICKLE: pop <= ($urandom_range(0, 7) == 0);
      default:       pop <= 1'b1;
    endcase
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && pop && !empty) begin
      if (frame_results_q.size() == 0) begin
        $error("result beat with nothing expected (index %0d)", payload_index);
        fail_count++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("frame_ok",       want.ok,   frame_ok);
        check_field("function_code",  want.func, function_code);
        check_field("payload_length", want.len,  payload_length);
        check_field("payload_index",  want.idx,  payload_index);
        check_field("payload_byte",   want.data, payload_byte);
        check_field("frame_sum",      want.sum,  frame_sum);
        check_field("ack_wanted",     want.ack,  ack_wanted);
        check_field("last",           want.last, last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_header_length_sum_frame_receiver NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // One beat: optional idle gap between bursts, then hold push until full is low.
  task automatic push_rx_byte(input logic [7:0] b);
    int gap;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        repeat (gap) @(negedge clk_i) push <= 1'b0;
      end
      burst_left--;
    end
    @(negedge clk_i);
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    parse_byte_into_frames(b);
  endtask

  // Drop push and wait until every owed result has been popped, plus the
  // pipeline depth in case the last byte caused nothing.
  task automatic wait_results_drained();
    @(negedge clk_i) push <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Full frame; bad_sum spoils the checksum, alt_fill makes the payload 00/FF,
  // cut_at > 0 keeps only that many leading bytes and adds one random byte.
  task automatic send_frame(input logic [7:0] func, input int len, input bit bad_sum,
                            input bit alt_fill, input int cut_at = 0);
    logic [7:0] seq [$];
    logic [7:0] sum;
    sum = '0;
    seq = '{HDR_FIRST, HDR_SECOND, func, 8'(len)};
    for (int i = 0; i < len; i++)
      seq.push_back(alt_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
    foreach (seq[i]) sum = sum + seq[i];
    seq.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
    if (cut_at > 0) begin
      while (seq.size() > cut_at) void'(seq.pop_back());
      seq.push_back(8'($urandom));
    end
    foreach (seq[i]) push_rx_byte(seq[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, the ack range edges and a bad checksum.
  task automatic test_frame_extremes();
    send_frame(8'h01, 1, 1'b0, 1'b1);           // smallest func, shortest frame
    send_frame(FUNC_END - 1'b1, 49, 1'b0, 1'b1);  // largest func, longest frame
    send_frame(ACK_LOW, 2, 1'b0, 1'b0);
    send_frame(ACK_HIGH, 3, 1'b0, 1'b0);
    send_frame(ACK_LOW - 1'b1, 2, 1'b0, 1'b0);   // just outside the ack range
    send_frame(ACK_HIGH + 1'b1, 2, 1'b0, 1'b0);
    send_frame(8'h42, 5, 1'b1, 1'b0);           // checksum mismatch
  endtask

  // Every way a header can go wrong, then a clean frame to show recovery.
  task automatic test_broken_headers();
    logic [7:0] seq [$];
    seq = '{
      8'h00, 8'hFF, HDR_SECOND,                          // junk while idle
      HDR_FIRST, 8'h00,                                  // wrong second header
      HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'h01, 8'h01,    // repeated AA is not a new start
      HDR_FIRST, HDR_SECOND, 8'h00,                      // function code zero
      HDR_FIRST, HDR_SECOND, FUNC_END,                   // function code past range
      HDR_FIRST, HDR_SECOND, 8'hFF,
      HDR_FIRST, HDR_SECOND, 8'h07, 8'(LENGTH_LIMIT),    // length at the limit
      HDR_FIRST, HDR_SECOND, 8'h07, 8'hFF,
      HDR_FIRST, HDR_SECOND, 8'h07, 8'h00, HDR_FIRST,    // zero length swallows next byte
      HDR_SECOND, 8'h07, 8'h01
    };
    foreach (seq[i]) push_rx_byte(seq[i]);
    send_frame(8'h07, 1, 1'b0, 1'b0);
  endtask

  // Mostly well-formed frames with random content, some bad sums and cut frames.
  task automatic test_random_frames(input int n_bytes);
    int          stop_at;
    int          kind;
    int          len;
    logic [7:0]  func;
    bit          paused;
    stop_at = bytes_sent + n_bytes;
    paused  = 1'b0;
    while (bytes_sent < stop_at) begin
      // first stretch runs without sender gaps
      sender_idles = (bytes_sent > stop_at - (2 * n_bytes) / 3);
      if (!paused && bytes_sent > stop_at - n_bytes / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 19);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 49) : $urandom_range(1, 8);
      func = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(ACK_LOW, ACK_HIGH))
                                         : 8'($urandom_range(1, FUNC_END - 1));
      if (kind < 15)
        send_frame(func, len, 1'b0, 1'b0);
      else if (kind < 17)
        send_frame(func, len, 1'b1, 1'b0);
      else
        send_frame(func, len, 1'b0, 1'b0, $urandom_range(1, len + 4));
    end
    sender_idles = 1'b1;
  endtask

  // Raw noise, biased toward header bytes so the early phases get hit.
  task automatic test_random_noise(input int n_bytes);
    logic [7:0] b;
    repeat (n_bytes) begin
      case ($urandom_range(0, 5))
        0:       b = HDR_FIRST;
        1:       b = HDR_SECOND;
        default: b = 8'($urandom);
      endcase
      push_rx_byte(b);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_frame_extremes();
    test_broken_headers();
    test_random_frames(260);
    test_random_noise(80);

    @(negedge clk_i) push <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_header_length_sum_frame_receiver OK");
    end else begin
      $display("tb_header_length_sum_frame_receiver NOT OK");
    end
    $finish;
  end

endmodule
